/* hdl/bmmp_pkg.sv */
// Shared types and constants for the big-endian main memory with supervisor protect.
// Holds the command codes, the word structs of both channels and the bank write bundle.
// No dependencies.
package bmmp_pkg;

    // Default store depth in 16-bit words
    localparam int unsigned MEM_WORDS_DEF = 1048576;

    // Field widths
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned FC_W   = 3;
    localparam int unsigned DATA_W = 32;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 25;
    localparam int unsigned END_W      = 22;
    localparam int unsigned LIMIT_W    = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_END       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPERVISOR_LIMIT = 1'd1;

    localparam logic [END_W-1:0]   END_RST   = 22'd2097152;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 25'd0;

    // Function code for supervisor data space
    localparam logic [FC_W-1:0] FC_SUPER_DATA = 3'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_RD_BYTE = 3'd0,
        CMD_RD_WORD = 3'd1,
        CMD_RD_LONG = 3'd2,
        CMD_WR_BYTE = 3'd3,
        CMD_WR_WORD = 3'd4,
        CMD_WR_LONG = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_WORD = 2'd1,
        SZ_LONG = 2'd2
    } t_size;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [FC_W-1:0]   space_code;
        logic [DATA_W-1:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bus_error;
    } t_out_word;

    // Write request to one word bank: byte-lane enables (high, low) and data
    typedef struct packed {
        logic [1:0]  lane_we;
        logic [15:0] data;
    } t_bank_wr;

endpackage

/* hdl/bmmp_bank.sv */
// One bank of 16-bit words with high/low byte-lane writes and a registered read.
// Depends on bmmp_pkg for the write bundle type.
module bmmp_bank #(
    parameter int unsigned ROWS  = 2,
    parameter int unsigned ROW_W = 1
) (
    input  logic                i_clk,
    input  logic [ROW_W-1:0]    i_row,
    input  bmmp_pkg::t_bank_wr  i_wr,
    input  logic                i_re,
    output logic [15:0]         o_rdata
);
    import bmmp_pkg::*;

    logic [15:0] r_mem [ROWS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.lane_we[1]) begin
            r_mem[i_row][15:8] <= i_wr.data[15:8];
        end
        if (i_wr.lane_we[0]) begin
            r_mem[i_row][7:0] <= i_wr.data[7:0];
        end
        if (i_re) begin
            r_rdata <= r_mem[i_row];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/big_endian_main_memory_protect.sv */
// Top level of the big-endian main memory with supervisor write protection.
// Depends on bmmp_pkg and instantiates two bmmp_bank word banks (even and odd words).
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
//   out     | output    | o_out_valid / i_out_stall  | o_out_word (t_out_word)
//   cfg     | input     | i_cfg_we (no stall)        | i_cfg_index, i_cfg_data
//
// The result word passes stage 1, stage 2 and the result register in turn; one word is
// taken per cycle while the output side drains, since each bank port serves one access a cycle.
// After reset the banks are swept to zero, one row of each bank a cycle, with o_in_stall
// high until every row is cleared; configuration writes are taken meanwhile.
// A stall on the output holds the result register, then the read stage, then the input.
module big_endian_main_memory_protect #(
    parameter int unsigned MEM_WORDS = bmmp_pkg::MEM_WORDS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bmmp_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bmmp_pkg::t_out_word                  o_out_word,
    input  logic                                 i_cfg_we,
    input  logic [bmmp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bmmp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bmmp_pkg::*;

    // Even words live in one bank, odd words in the other, so a long access
    // touches each bank exactly once.
    localparam int unsigned ROWS  = (MEM_WORDS + 1) / 2;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [24:0] CAP   = 25'(2 * MEM_WORDS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // Round the installed size up to even and cap it at the store size
    function automatic logic [24:0] eff_end(input logic [END_W-1:0] v);
        logic [24:0] e;
        e = {2'b00, ({1'b0, v[END_W-1:1]} + 22'(v[0])), 1'b0};
        return (e > CAP) ? CAP : e;
    endfunction

    // Configuration: keep the effective end rather than the raw size
    logic [24:0]        r_end;
    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end   <= eff_end(END_RST);
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MEMORY_END:       r_end   <= eff_end(i_cfg_data[END_W-1:0]);
                CFG_SUPERVISOR_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clearing sweep after reset
    logic             r_clearing;
    logic [ROW_W-1:0] r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == LAST_ROW) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Decode of the incoming word: fault checks, bank rows, lane enables
    logic [23:0]      s0_a;
    logic [22:0]      s0_i;
    logic             s0_ok;
    logic             s0_write;
    t_size            s0_size;
    logic             s0_fault;
    logic [ROW_W-1:0] s0_even_row;
    logic [ROW_W-1:0] s0_odd_row;
    t_bank_wr         s0_even_wr;
    t_bank_wr         s0_odd_wr;
    logic [7:0]       s0_byte;
    logic [21:0]      s0_half;

    always_comb begin
        s0_a     = i_in_word.address[23:0];
        s0_i     = s0_a[23:1];
        s0_half  = s0_i[22:1];
        s0_byte  = i_in_word.write_data[7:0];
        s0_ok    = 1'b1;
        s0_write = 1'b0;
        s0_size  = SZ_BYTE;
        case (i_in_word.command)
            CMD_RD_BYTE: s0_size = SZ_BYTE;
            CMD_RD_WORD: s0_size = SZ_WORD;
            CMD_RD_LONG: s0_size = SZ_LONG;
            CMD_WR_BYTE: begin s0_size = SZ_BYTE; s0_write = 1'b1; end
            CMD_WR_WORD: begin s0_size = SZ_WORD; s0_write = 1'b1; end
            CMD_WR_LONG: begin s0_size = SZ_LONG; s0_write = 1'b1; end
            default:     s0_ok = 1'b0;
        endcase

        s0_fault = 1'b0;
        if ({1'b0, s0_a} >= r_end) begin
            s0_fault = 1'b1;
        end
        if (s0_size == SZ_LONG && ({1'b0, s0_a[23:1], 1'b0} + 25'd2) >= r_end) begin
            s0_fault = 1'b1;
        end
        if (s0_write && i_in_word.space_code != FC_SUPER_DATA
                && {1'b0, s0_a} < r_limit) begin
            s0_fault = 1'b1;
        end
        s0_fault = s0_fault && s0_ok;

        // A long starting on an odd word continues in the next even row
        s0_odd_row  = s0_half[ROW_W-1:0];
        s0_even_row = s0_i[0] ? ROW_W'(s0_half + 22'd1) : s0_half[ROW_W-1:0];

        s0_even_wr = '0;
        s0_odd_wr  = '0;
        if (s0_write && s0_ok && !s0_fault) begin
            case (s0_size)
                SZ_BYTE: begin
                    if (s0_i[0]) begin
                        s0_odd_wr.lane_we = s0_a[0] ? 2'b01 : 2'b10;
                        s0_odd_wr.data    = {s0_byte, s0_byte};
                    end else begin
                        s0_even_wr.lane_we = s0_a[0] ? 2'b01 : 2'b10;
                        s0_even_wr.data    = {s0_byte, s0_byte};
                    end
                end
                SZ_WORD: begin
                    if (s0_i[0]) begin
                        s0_odd_wr.lane_we = 2'b11;
                        s0_odd_wr.data    = i_in_word.write_data[15:0];
                    end else begin
                        s0_even_wr.lane_we = 2'b11;
                        s0_even_wr.data    = i_in_word.write_data[15:0];
                    end
                end
                default: begin
                    // High half to the first word, low half to the next
                    s0_even_wr.lane_we = 2'b11;
                    s0_odd_wr.lane_we  = 2'b11;
                    s0_even_wr.data = s0_i[0] ? i_in_word.write_data[15:0]
                                              : i_in_word.write_data[31:16];
                    s0_odd_wr.data  = s0_i[0] ? i_in_word.write_data[31:16]
                                              : i_in_word.write_data[15:0];
                end
            endcase
        end
    end

    // Stage 1: bank access; stage 2: read data in the banks' registers
    logic             r_s1_v;
    logic             r_s1_ok;
    logic             r_s1_write;
    t_size            r_s1_size;
    logic             r_s1_fault;
    logic             r_s1_a0;
    logic             r_s1_i0;
    logic [ROW_W-1:0] r_s1_even_row;
    logic [ROW_W-1:0] r_s1_odd_row;
    t_bank_wr         r_s1_even_wr;
    t_bank_wr         r_s1_odd_wr;

    logic             r_s2_v;
    logic             r_s2_ok;
    logic             r_s2_write;
    t_size            r_s2_size;
    logic             r_s2_fault;
    logic             r_s2_a0;
    logic             r_s2_i0;

    logic             r_out_v;
    t_out_word        r_out;

    logic             s2_adv;
    logic             s1_adv;
    logic             in_take;

    assign s2_adv     = r_s2_v && (!r_out_v || !i_out_stall);
    assign s1_adv     = r_s1_v && (!r_s2_v || s2_adv);
    assign o_in_stall = r_clearing || (r_s1_v && !s1_adv);
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            // Advance the input into stage 1, or drop stage 1 once it moves on
            if (in_take) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_ok       <= s0_ok;
            r_s1_write    <= s0_write;
            r_s1_size     <= s0_size;
            r_s1_fault    <= s0_fault;
            r_s1_a0       <= s0_a[0];
            r_s1_i0       <= s0_i[0];
            r_s1_even_row <= s0_even_row;
            r_s1_odd_row  <= s0_odd_row;
            r_s1_even_wr  <= s0_even_wr;
            r_s1_odd_wr   <= s0_odd_wr;
        end
        if (s1_adv) begin
            r_s2_ok    <= r_s1_ok;
            r_s2_write <= r_s1_write;
            r_s2_size  <= r_s1_size;
            r_s2_fault <= r_s1_fault;
            r_s2_a0    <= r_s1_a0;
            r_s2_i0    <= r_s1_i0;
        end
    end

    // Bank ports: the clearing sweep owns them until it ends
    logic [ROW_W-1:0] even_row;
    logic [ROW_W-1:0] odd_row;
    t_bank_wr         even_wr;
    t_bank_wr         odd_wr;
    logic [15:0]      even_rdata;
    logic [15:0]      odd_rdata;

    always_comb begin
        if (r_clearing) begin
            even_row = r_clr_row;
            odd_row  = r_clr_row;
            even_wr  = '{lane_we: 2'b11, data: 16'h0000};
            odd_wr   = '{lane_we: 2'b11, data: 16'h0000};
        end else begin
            even_row = r_s1_even_row;
            odd_row  = r_s1_odd_row;
            even_wr  = s1_adv ? r_s1_even_wr : '0;
            odd_wr   = s1_adv ? r_s1_odd_wr  : '0;
        end
    end

    bmmp_bank #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_row   (even_row),
        .i_wr    (even_wr),
        .i_re    (s1_adv),
        .o_rdata (even_rdata)
    );

    bmmp_bank #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_row   (odd_row),
        .i_wr    (odd_wr),
        .i_re    (s1_adv),
        .o_rdata (odd_rdata)
    );

    // Assemble the result: first word from the bank of the start address
    logic [15:0] first_w;
    logic [15:0] second_w;
    t_out_word   s2_res;

    always_comb begin
        first_w  = r_s2_i0 ? odd_rdata  : even_rdata;
        second_w = r_s2_i0 ? even_rdata : odd_rdata;
        s2_res   = '0;
        s2_res.bus_error = r_s2_fault;
        if (r_s2_ok && !r_s2_write && !r_s2_fault) begin
            case (r_s2_size)
                SZ_BYTE: s2_res.read_data = {24'h000000,
                                             r_s2_a0 ? first_w[7:0] : first_w[15:8]};
                SZ_WORD: s2_res.read_data = {16'h0000, first_w};
                default: s2_res.read_data = {first_w, second_w};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out <= s2_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

endmodule
